FILE: design/csp_pkg.sv
// Shared types and constants for the carrier smoothed pseudorange block.
// Used by every module of the block except csp_div; depends on nothing.
package csp_pkg;

  localparam int CSP_COUNT_WIDTH = 16;
  localparam int CSP_CFG_INDEX_WIDTH = 3;

  localparam logic [2:0] CFG_IONOFREE_MODE     = 3'd0;
  localparam logic [2:0] CFG_COEF_FIRST        = 3'd1;
  localparam logic [2:0] CFG_COEF_SECOND       = 3'd2;
  localparam logic [2:0] CFG_WAVELENGTH_FIRST  = 3'd3;
  localparam logic [2:0] CFG_WAVELENGTH_SECOND = 3'd4;

  localparam logic [31:0] RST_COEF_FIRST        = 32'd683363588;
  localparam logic [31:0] RST_COEF_SECOND       = 32'd414928132;
  localparam logic [31:0] RST_WAVELENGTH_FIRST  = 32'd51081569;
  localparam logic [31:0] RST_WAVELENGTH_SECOND = 32'd65554679;

  localparam logic [1:0] QC_NO_ARC        = 2'd0;
  localparam logic [1:0] QC_STARTED       = 2'd1;
  localparam logic [1:0] QC_STARTED_EQUAL = 2'd2;
  localparam logic [1:0] QC_SKIPPED       = 2'd3;

  typedef struct packed {
    logic               start_arc;
    logic signed [47:0] code_first;
    logic signed [47:0] code_second;
    logic signed [47:0] phase_first;
    logic signed [47:0] phase_second;
    logic [31:0]        var_code_first;
    logic [31:0]        var_code_second;
    logic [31:0]        var_phase_first;
    logic [31:0]        var_phase_second;
  } csp_in_t;

  typedef struct packed {
    logic signed [47:0] smoothed_first;
    logic signed [47:0] smoothed_second;
    logic [31:0]        var_smoothed_first;
    logic [31:0]        var_smoothed_second;
    logic [1:0]         quality_code;
    logic [15:0]        arc_length;
  } csp_out_t;

  typedef struct packed {
    csp_in_t word;
    logic    codes_equal;
  } csp_entry_t;

  typedef struct packed {
    logic        ionofree_mode;
    logic [31:0] coef_first;
    logic [31:0] coef_second;
    logic [31:0] wavelength_first;
    logic [31:0] wavelength_second;
  } csp_cfg_t;

  typedef enum logic [1:0] {SH_RND28, SH_RND30, SH_NONE} csp_shift_t;

  typedef struct packed {
    logic [47:0] mag;
    logic        neg;
    logic [31:0] fac;
    csp_shift_t  shift;
  } csp_mul_req_t;

endpackage

FILE: design/carrier_smoothed_pseudorange.sv
// Dual-frequency carrier smoothing filter with variance-based weight.
// Top level: configuration registers, input queue and execution sequencer.
// Depends on csp_pkg, csp_front and csp_back.
//
// Input words (in_valid/in_ready) carry one dual-frequency epoch each; output
// words (out_valid/out_ready) carry one result per epoch, in order.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself leaves this unchecked. A
// two-word queue takes epochs while the sequencer works and while a result
// waits in the output register. The sequencer takes one epoch at a time
// through one shared multiplier and one radix-2 divider (up to three quotients
// for each weight).
// Reset clears the filter state, the queue and the output valid flag, and
// loads the default coefficients and wavelengths.
// A stalled receiver holds the result; the queue then fills and drops in_ready.
module carrier_smoothed_pseudorange #(
  parameter int COUNT_WIDTH = csp_pkg::CSP_COUNT_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  csp_pkg::csp_in_t                        in_word,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output csp_pkg::csp_out_t                       out_word,
  input  logic                                    cfg_wr_en,
  input  logic [csp_pkg::CSP_CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [31:0]                             cfg_data
);

  csp_pkg::csp_cfg_t   cfg_r;
  logic                q_valid;
  logic                q_pop;
  csp_pkg::csp_entry_t q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ionofree_mode     <= 1'b0;
      cfg_r.coef_first        <= csp_pkg::RST_COEF_FIRST;
      cfg_r.coef_second       <= csp_pkg::RST_COEF_SECOND;
      cfg_r.wavelength_first  <= csp_pkg::RST_WAVELENGTH_FIRST;
      cfg_r.wavelength_second <= csp_pkg::RST_WAVELENGTH_SECOND;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        csp_pkg::CFG_IONOFREE_MODE:     cfg_r.ionofree_mode     <= cfg_data[0];
        csp_pkg::CFG_COEF_FIRST:        cfg_r.coef_first        <= cfg_data;
        csp_pkg::CFG_COEF_SECOND:       cfg_r.coef_second       <= cfg_data;
        csp_pkg::CFG_WAVELENGTH_FIRST:  cfg_r.wavelength_first  <= cfg_data;
        csp_pkg::CFG_WAVELENGTH_SECOND: cfg_r.wavelength_second <= cfg_data;
        default: ;
      endcase
    end
  end

  csp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_entry  (q_entry)
  );

  csp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

FILE: design/csp_front.sv
// Input side: accepts words, flags equal codes, holds them in a two-entry queue.
// Depends on csp_pkg.
module csp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csp_pkg::csp_in_t    in_word,
  output logic                q_valid,
  input  logic                q_pop,
  output csp_pkg::csp_entry_t q_entry
);

  csp_pkg::csp_entry_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_entry  = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].word        <= in_word;
      mem_r[wr_ptr_r].codes_equal <= (in_word.code_first == in_word.code_second);
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/csp_mul.sv
// Shared multiplier: 48 x 32 product of two partial products, optional rounding shift.
// Depends on csp_pkg.
module csp_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  csp_pkg::csp_mul_req_t req,
  output logic                  done,
  output logic [63:0]           u_res,
  output logic signed [53:0]    s_res
);

  csp_pkg::csp_mul_req_t req_r;
  logic [3:0]  stage_r;
  logic [63:0] lo_r;
  logic [47:0] hi_r;
  logic [63:0] u_r;
  logic [79:0] prod;
  logic [53:0] rnd28;
  logic [51:0] rnd30;

  assign prod  = {hi_r, 32'd0} + {16'd0, lo_r};
  assign rnd28 = ({1'b0, prod[79:27]} + 54'd1) >> 1;
  assign rnd30 = ({1'b0, prod[79:29]} + 52'd1) >> 1;

  assign done  = stage_r[3];
  assign u_res = u_r;
  assign s_res = req_r.neg ? -$signed(u_r[53:0]) : $signed(u_r[53:0]);

  always_ff @(posedge clk) begin
    if (start) req_r <= req;
    if (stage_r[0]) lo_r <= 64'(req_r.mag[31:0]) * 64'(req_r.fac);
    if (stage_r[1]) hi_r <= 48'(req_r.mag[47:32]) * 48'(req_r.fac);
    if (stage_r[2]) begin
      unique case (req_r.shift)
        csp_pkg::SH_RND28: u_r <= 64'(rnd28);
        csp_pkg::SH_RND30: u_r <= 64'(rnd30);
        csp_pkg::SH_NONE:  u_r <= prod[63:0];
        default:           u_r <= prod[63:0];
      endcase
    end
    if (!rst_n) begin
      stage_r <= 4'd0;
    end else begin
      stage_r <= {stage_r[2:0], start};
    end
  end

endmodule

FILE: design/csp_div.sv
// Shared restoring divider, one quotient bit a cycle, 32 quotient bits.
// The high half of the dividend must be below the divisor. Depends on nothing.
module csp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic [32:0] rem_r;
  logic [31:0] low_r;
  logic [32:0] dsr_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [34:0] diff;
  logic        ge;

  assign diff = {1'b0, rem_r, low_r[31]} - {2'b00, dsr_r};
  assign ge   = !diff[34];
  assign done = done_r;
  assign quot = low_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[63:32]};
      low_r <= dividend[31:0];
      dsr_r <= divisor;
    end else if (cnt_r != 6'd0) begin
      rem_r <= ge ? diff[32:0] : {rem_r[31:0], low_r[31]};
      low_r <= {low_r[30:0], ge};
    end
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 6'd1);
      if (start) cnt_r <= 6'd32;
      else if (cnt_r != 6'd0) cnt_r <= cnt_r - 6'd1;
    end
  end

endmodule

FILE: design/csp_back.sv
// Execution side: filter state and the step sequencer over the shared multiplier and divider.
// Depends on csp_pkg, csp_mul and csp_div.
module csp_back #(
  parameter int COUNT_WIDTH = csp_pkg::CSP_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  csp_pkg::csp_cfg_t   cfg,
  input  logic                q_valid,
  input  csp_pkg::csp_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output csp_pkg::csp_out_t   out_word
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE, ST_DP1, ST_DP2, ST_D1C, ST_D2C, ST_IRA, ST_IRB,
    ST_IVA, ST_IVB, ST_IVC, ST_IVD, ST_PRED, ST_WGT, ST_DIV1, ST_DIV2,
    ST_DIVN, ST_SM, ST_VM, ST_VMN, ST_VDV, ST_FIN, ST_OUT
  } state_t;

  localparam logic signed [55:0] RangeMax = 56'sh00_7FFF_FFFF_FFFF;
  localparam logic signed [55:0] RangeMin = 56'shFF_8000_0000_0000;

  function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
    if (v > RangeMax) return 48'(RangeMax);
    if (v < RangeMin) return 48'(RangeMin);
    return 48'(v);
  endfunction

  function automatic logic [31:0] sat32(input logic [41:0] v);
    return (v > 42'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic csp_pkg::csp_mul_req_t smul_req(input logic signed [47:0] a,
                                                     input logic [31:0] b,
                                                     input csp_pkg::csp_shift_t sh);
    csp_pkg::csp_mul_req_t r;
    r.neg   = a[47];
    r.mag   = a[47] ? 48'(-a) : 48'(a);
    r.fac   = b;
    r.shift = sh;
    return r;
  endfunction

  state_t              state_r;
  logic                issued_r;
  csp_pkg::csp_entry_t cur_r;
  logic                mode_r;
  logic                iv_sel_r;
  logic                k_r;
  logic [1:0]          status_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic signed [47:0]  prev1_r, prev2_r, fr1_r, fr2_r;
  logic [31:0]         fv1_r, fv2_r;
  logic signed [47:0]  d1_r, d2_r, d_r;
  logic signed [53:0]  t1_r;
  logic signed [47:0]  code_w_r, pr_w_r, pr2_r;
  logic [31:0]         vc_w_r, vp_w_r;
  logic [47:0]         ta_r;
  logic [40:0]         tb_r;
  logic [31:0]         q1_r, q2_r, w_r;
  logic [63:0]         prod_r;
  logic                out_valid_r;
  csp_pkg::csp_out_t   out_word_r;

  csp_pkg::csp_mul_req_t mul_req;
  logic                mul_start, mul_done, mul_op;
  logic [63:0]         mul_u;
  logic signed [53:0]  mul_s;
  logic                div_start, div_done, div_op;
  logic [63:0]         div_dividend;
  logic [32:0]         div_divisor;
  logic [31:0]         div_quot;

  logic signed [47:0]  dp1, dp2, dd, d_new, pr1, pr2, pr_if, fr_new, ifr_new;
  logic [31:0]         iv_sum;
  logic [32:0]         s_sum;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                op_done;

  assign dp1     = sat48(56'(cur_r.word.phase_first) - 56'(prev1_r));
  assign dp2     = sat48(56'(cur_r.word.phase_second) - 56'(prev2_r));
  assign dd      = sat48(56'(code_w_r) - 56'(pr_w_r));
  assign d_new   = sat48(56'(t1_r) - 56'(mul_s));
  assign ifr_new = d_new;
  assign pr1     = sat48(56'(fr1_r) + 56'(sat48(56'(d_r) + 56'(d_r) - 56'(d1_r))));
  assign pr2     = sat48(56'(fr2_r) + 56'(sat48(56'(d_r) + 56'(d_r) - 56'(d2_r))));
  assign pr_if   = sat48(56'(fr1_r) + 56'(d_r));
  assign fr_new  = sat48(56'(pr_w_r) + 56'(mul_s));
  assign iv_sum  = sat32(42'(tb_r) + 42'(mul_u[40:0]));
  assign s_sum   = 33'(vc_w_r) + 33'(vp_w_r);
  assign cnt_inc = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
  assign op_done = mul_done || div_done;

  always_comb begin
    mul_req = '0;
    mul_op  = 1'b1;
    unique case (state_r)
      ST_DP1: mul_req = smul_req(dp1, cfg.wavelength_first, csp_pkg::SH_RND28);
      ST_DP2: mul_req = smul_req(dp2, cfg.wavelength_second, csp_pkg::SH_RND28);
      ST_D1C: mul_req = smul_req(d1_r, cfg.coef_first, csp_pkg::SH_RND28);
      ST_D2C: mul_req = smul_req(d2_r, cfg.coef_second, csp_pkg::SH_RND28);
      ST_IRA: mul_req = smul_req(cur_r.word.code_first, cfg.coef_first, csp_pkg::SH_RND28);
      ST_IRB: mul_req = smul_req(cur_r.word.code_second, cfg.coef_second, csp_pkg::SH_RND28);
      ST_IVA: mul_req = '{mag: 48'(iv_sel_r ? cur_r.word.var_phase_first
                                            : cur_r.word.var_code_first),
                          neg: 1'b0, fac: cfg.coef_first, shift: csp_pkg::SH_RND28};
      ST_IVB: mul_req = '{mag: ta_r, neg: 1'b0, fac: cfg.coef_first,
                          shift: csp_pkg::SH_RND28};
      ST_IVC: mul_req = '{mag: 48'(iv_sel_r ? cur_r.word.var_phase_second
                                            : cur_r.word.var_code_second),
                          neg: 1'b0, fac: cfg.coef_second, shift: csp_pkg::SH_RND28};
      ST_IVD: mul_req = '{mag: ta_r, neg: 1'b0, fac: cfg.coef_second,
                          shift: csp_pkg::SH_RND28};
      ST_SM:  mul_req = smul_req(dd, w_r, csp_pkg::SH_RND30);
      ST_VM:  mul_req = '{mag: 48'(vc_w_r), neg: 1'b0, fac: w_r, shift: csp_pkg::SH_RND30};
      ST_VMN: mul_req = '{mag: 48'(cnt_r - COUNT_WIDTH'(1)), neg: 1'b0, fac: vp_w_r,
                          shift: csp_pkg::SH_NONE};
      default: mul_op = 1'b0;
    endcase
  end

  always_comb begin
    div_dividend = '0;
    div_divisor  = 33'(cnt_r);
    div_op       = 1'b1;
    unique case (state_r)
      ST_DIV1: begin
        div_dividend = 64'(vp_w_r) << 30;
        div_divisor  = s_sum;
      end
      ST_DIV2: begin
        div_dividend = 64'(vc_w_r) << 30;
        div_divisor  = s_sum;
      end
      ST_DIVN: div_dividend = 64'(q2_r);
      ST_VDV:  div_dividend = prod_r + 64'(vc_w_r);
      default: div_op = 1'b0;
    endcase
  end

  assign mul_start = mul_op && !issued_r;
  assign div_start = div_op && !issued_r;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  csp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .u_res (mul_u),
    .s_res (mul_s)
  );

  csp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      status_r    <= csp_pkg::QC_NO_ARC;
      cnt_r       <= '0;
      prev1_r     <= '0;
      prev2_r     <= '0;
      fr1_r       <= '0;
      fr2_r       <= '0;
      fv1_r       <= '0;
      fv2_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_OUT)) out_valid_r <= 1'b0;
      if ((mul_op || div_op) && !issued_r) issued_r <= 1'b1;
      if ((mul_op || div_op) && issued_r && op_done) issued_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_entry;
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          mode_r   <= cfg.ionofree_mode;
          iv_sel_r <= 1'b0;
          if (cur_r.word.start_arc) begin
            status_r <= cur_r.codes_equal ? csp_pkg::QC_STARTED_EQUAL : csp_pkg::QC_STARTED;
            cnt_r    <= COUNT_WIDTH'(1);
            prev1_r  <= cur_r.word.phase_first;
            prev2_r  <= cur_r.word.phase_second;
            if (!cfg.ionofree_mode) begin
              fr1_r   <= cur_r.word.code_first;
              fr2_r   <= cur_r.word.code_second;
              fv1_r   <= cur_r.word.var_code_first;
              fv2_r   <= cur_r.word.var_code_second;
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_IRA;
            end
          end else if (status_r == csp_pkg::QC_NO_ARC) begin
            state_r <= ST_OUT;
          end else if (cur_r.codes_equal) begin
            status_r <= csp_pkg::QC_SKIPPED;
            state_r  <= ST_OUT;
          end else begin
            cnt_r   <= cnt_inc;
            state_r <= ST_DP1;
          end
        end
        ST_DP1: if (issued_r && op_done) begin
          d1_r    <= sat48(56'(mul_s));
          state_r <= ST_DP2;
        end
        ST_DP2: if (issued_r && op_done) begin
          d2_r    <= sat48(56'(mul_s));
          state_r <= ST_D1C;
        end
        ST_D1C: if (issued_r && op_done) begin
          t1_r    <= mul_s;
          state_r <= ST_D2C;
        end
        ST_D2C: if (issued_r && op_done) begin
          d_r     <= d_new;
          state_r <= mode_r ? ST_IRA : ST_PRED;
        end
        ST_IRA: if (issued_r && op_done) begin
          t1_r    <= mul_s;
          state_r <= ST_IRB;
        end
        ST_IRB: if (issued_r && op_done) begin
          code_w_r <= ifr_new;
          state_r  <= ST_IVA;
        end
        ST_IVA: if (issued_r && op_done) begin
          ta_r    <= mul_u[47:0];
          state_r <= ST_IVB;
        end
        ST_IVB: if (issued_r && op_done) begin
          tb_r    <= mul_u[40:0];
          state_r <= ST_IVC;
        end
        ST_IVC: if (issued_r && op_done) begin
          ta_r    <= mul_u[47:0];
          state_r <= ST_IVD;
        end
        ST_IVD: if (issued_r && op_done) begin
          if (iv_sel_r) begin
            vp_w_r  <= iv_sum;
            state_r <= ST_PRED;
          end else if (cur_r.word.start_arc) begin
            fr1_r   <= code_w_r;
            fv1_r   <= iv_sum;
            state_r <= ST_OUT;
          end else begin
            vc_w_r   <= iv_sum;
            iv_sel_r <= 1'b1;
            state_r  <= ST_IVA;
          end
        end
        ST_PRED: begin
          if (mode_r) begin
            pr_w_r <= pr_if;
          end else begin
            pr_w_r   <= pr1;
            pr2_r    <= pr2;
            code_w_r <= cur_r.word.code_first;
            vc_w_r   <= cur_r.word.var_code_first;
            vp_w_r   <= cur_r.word.var_phase_first;
            k_r      <= 1'b0;
          end
          state_r <= ST_WGT;
        end
        ST_WGT: begin
          if (s_sum == 33'd0) begin
            q1_r    <= 32'd0;
            q2_r    <= 32'h4000_0000;
            state_r <= ST_DIVN;
          end else begin
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: if (issued_r && op_done) begin
          q1_r    <= div_quot;
          state_r <= ST_DIV2;
        end
        ST_DIV2: if (issued_r && op_done) begin
          q2_r    <= div_quot;
          state_r <= ST_DIVN;
        end
        ST_DIVN: if (issued_r && op_done) begin
          w_r     <= q1_r + div_quot;
          state_r <= ST_SM;
        end
        ST_SM: if (issued_r && op_done) begin
          if (!mode_r && k_r) fr2_r <= fr_new;
          else fr1_r <= fr_new;
          state_r <= mode_r ? ST_VMN : ST_VM;
        end
        ST_VM: if (issued_r && op_done) begin
          if (k_r) begin
            fv2_r   <= mul_u[31:0];
            state_r <= ST_FIN;
          end else begin
            fv1_r    <= mul_u[31:0];
            k_r      <= 1'b1;
            pr_w_r   <= pr2_r;
            code_w_r <= cur_r.word.code_second;
            vc_w_r   <= cur_r.word.var_code_second;
            vp_w_r   <= cur_r.word.var_phase_second;
            state_r  <= ST_WGT;
          end
        end
        ST_VMN: if (issued_r && op_done) begin
          prod_r  <= mul_u;
          state_r <= ST_VDV;
        end
        ST_VDV: if (issued_r && op_done) begin
          fv1_r   <= div_quot;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          prev1_r <= cur_r.word.phase_first;
          prev2_r <= cur_r.word.phase_second;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                    <= 1'b1;
            out_word_r.smoothed_first      <= fr1_r;
            out_word_r.smoothed_second     <= fr2_r;
            out_word_r.var_smoothed_first  <= fv1_r;
            out_word_r.var_smoothed_second <= fv2_r;
            out_word_r.quality_code        <= status_r;
            out_word_r.arc_length          <= (33'(cnt_r) > 33'h0_FFFF) ? 16'hFFFF
                                                                        : 16'(cnt_r);
            state_r                        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/csp_checker.sv
// Port-level checks for carrier_smoothed_pseudorange, bound to the top level.
// Depends on csp_pkg.
module csp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input csp_pkg::csp_out_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_arc_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.quality_code != csp_pkg::QC_NO_ARC |-> out_word.arc_length != 16'd0)
    else $error("open arc with zero length");

  a_no_arc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.quality_code == csp_pkg::QC_NO_ARC |->
      out_word.arc_length == 16'd0 && out_word.smoothed_first == 48'sd0 &&
      out_word.var_smoothed_first == 32'd0)
    else $error("state not clear before first arc");

endmodule

bind carrier_smoothed_pseudorange csp_checker u_csp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
